// File: hw/rtl/kpsd_pkg.sv
// Shared types, constants and lookup functions for the keypad scanner.
// No dependencies; every other file in hw/rtl imports this package.
package kpsd_pkg;

    localparam int NUM_KEYS = 12;
    localparam int NUM_ROWS = 4;
    localparam int NUM_COLS = 3;

    localparam logic [7:0] SETTLE_MS_RESET = 8'd20;
    localparam logic [7:0] WAIT_COUNT_MAX  = 8'hFF;

    // Active-low row drive patterns, row 0 first.
    localparam logic [3:0] ROW_PAT_0 = 4'h7;
    localparam logic [3:0] ROW_PAT_1 = 4'hB;
    localparam logic [3:0] ROW_PAT_2 = 4'hD;
    localparam logic [3:0] ROW_PAT_3 = 4'hE;

    // ASCII codes of the keypad legends.
    localparam logic [6:0] ASCII_STAR = 7'h2A;
    localparam logic [6:0] ASCII_HASH = 7'h23;
    localparam logic [6:0] ASCII_ZERO = 7'h30;
    localparam logic [6:0] ASCII_NONE = 7'h00;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_WAIT   = 3'b010,
        PH_SECOND = 3'b100
    } kpsd_phase_t;

    typedef struct packed {
        logic [NUM_COLS-1:0] column_lines;
        logic                ms_tick;
    } kpsd_in_t;

    typedef struct packed {
        logic [3:0] row_drive;
        logic       key_valid;
        logic [6:0] key_code;
    } kpsd_out_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0] scan_first;
        logic [NUM_KEYS-1:0] scan_second;
        logic [NUM_KEYS-1:0] press_mask;
        logic [1:0]          row_index;
        kpsd_phase_t         phase;
        logic [7:0]          wait_count;
    } kpsd_state_t;

    function automatic logic [3:0] row_pattern(input logic [1:0] row);
        logic [3:0] pat;
        case (row)
            2'd0:    pat = ROW_PAT_0;
            2'd1:    pat = ROW_PAT_1;
            2'd2:    pat = ROW_PAT_2;
            default: pat = ROW_PAT_3;
        endcase
        return pat;
    endfunction

    // Keys 0..11 read '*','0','#','7','8','9','4','5','6','1','2','3'.
    function automatic logic [6:0] key_ascii(input logic [3:0] key);
        logic [6:0] code;
        case (key)
            4'd0:    code = ASCII_STAR;
            4'd1:    code = ASCII_ZERO;
            4'd2:    code = ASCII_HASH;
            4'd3:    code = ASCII_ZERO + 7'd7;
            4'd4:    code = ASCII_ZERO + 7'd8;
            4'd5:    code = ASCII_ZERO + 7'd9;
            4'd6:    code = ASCII_ZERO + 7'd4;
            4'd7:    code = ASCII_ZERO + 7'd5;
            4'd8:    code = ASCII_ZERO + 7'd6;
            4'd9:    code = ASCII_ZERO + 7'd1;
            4'd10:   code = ASCII_ZERO + 7'd2;
            4'd11:   code = ASCII_ZERO + 7'd3;
            default: code = ASCII_NONE;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/kpsd_step.sv
// Next-state and result logic for one column sample of the keypad scanner.
// Depends on kpsd_pkg.
module kpsd_step (
    input  kpsd_pkg::kpsd_state_t state_cur,
    input  kpsd_pkg::kpsd_in_t    item,
    input  logic [7:0]            settle_ms,
    output kpsd_pkg::kpsd_state_t state_new,
    output kpsd_pkg::kpsd_out_t   result
);
    import kpsd_pkg::*;

    // Merge one row sample into a scan word; row 0 starts a new word.
    function automatic logic [NUM_KEYS-1:0] merge_row(
        input logic [NUM_KEYS-1:0] word,
        input logic [1:0]          row,
        input logic [NUM_COLS-1:0] held
    );
        logic [NUM_KEYS-1:0] merged;
        case (row)
            2'd0:    merged = {held, 9'b0};
            2'd1:    merged = word | {3'b0, held, 6'b0};
            2'd2:    merged = word | {6'b0, held, 3'b0};
            default: merged = word | {9'b0, held};
        endcase
        return merged;
    endfunction

    logic [NUM_COLS-1:0] held;
    logic [7:0]          wait_inc;
    logic [NUM_KEYS-1:0] hit;
    logic [NUM_KEYS-1:0] lowbit;
    logic [NUM_KEYS-1:0] below;
    logic [NUM_KEYS-1:0] released;
    logic [3:0]          key_idx;
    logic                last_row;

    assign held     = ~item.column_lines;
    assign last_row = (state_cur.row_index == 2'(NUM_ROWS - 1));
    assign wait_inc = (item.ms_tick && state_cur.wait_count != WAIT_COUNT_MAX)
                      ? state_cur.wait_count + 8'd1 : state_cur.wait_count;

    always_comb
    begin
        state_new = state_cur;
        hit       = '0;
        lowbit    = '0;
        below     = '0;
        released  = '0;
        key_idx   = '0;
        result.key_valid = 1'b0;
        result.key_code  = ASCII_NONE;

        case (state_cur.phase)
            PH_WAIT:
            begin
                state_new.wait_count = wait_inc;
                if (wait_inc >= settle_ms)
                begin
                    state_new.phase     = PH_SECOND;
                    state_new.row_index = '0;
                end
            end
            PH_SECOND:
            begin
                state_new.scan_second = merge_row(state_cur.scan_second,
                                                  state_cur.row_index, held);
                if (last_row)
                begin
                    state_new.row_index = '0;
                    state_new.phase     = PH_FIRST;
                    // The lowest-numbered key held in both scans and not yet reported wins;
                    // keys released below it (all released keys if none wins) have their mask bits cleared.
                    hit    = state_new.scan_second & state_cur.scan_first
                             & ~state_cur.press_mask;
                    lowbit = hit & (~hit + 12'd1);
                    below  = (hit == '0) ? '1 : lowbit - 12'd1;
                    released = ~state_new.scan_second & below;
                    state_new.press_mask = (state_cur.press_mask & ~released) | lowbit;
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        if (lowbit[k])
                        begin
                            key_idx = key_idx | 4'(k);
                        end
                    end
                    if (hit != '0)
                    begin
                        result.key_valid = 1'b1;
                        result.key_code  = key_ascii(key_idx);
                    end
                end
                else
                begin
                    state_new.row_index = state_cur.row_index + 2'd1;
                end
            end
            default:
            begin
                state_new.scan_first = merge_row(state_cur.scan_first,
                                                 state_cur.row_index, held);
                if (last_row)
                begin
                    state_new.row_index  = '0;
                    state_new.wait_count = '0;
                    state_new.phase      = (settle_ms == '0) ? PH_SECOND : PH_WAIT;
                end
                else
                begin
                    state_new.row_index = state_cur.row_index + 2'd1;
                end
            end
        endcase

        result.row_drive = row_pattern(state_new.row_index);
    end

endmodule

// File: hw/rtl/keypad_scan_debounce.sv
// Top level of the 4x3 matrix keypad scanner with two-scan debounce.
// Depends on kpsd_pkg and kpsd_step.
//
// Each input transfer carries the active-low column sample for the row that
// the previous result asked for, plus a flag telling whether a millisecond
// passed since the last sample; each input transfer yields exactly one
// result transfer with the next row pattern to drive and, at the end of a
// second scan, possibly one newly pressed key as ASCII. The block takes one
// transfer per clock cycle while the output is not stalled: a sample is
// captured in an input register, the scan state is updated by one short
// level of logic, and the result lands in an output register, from which it
// is offered until it is taken. The input register keeps accepting while a
// result waits at the output, until both registers are full and the output
// is stalled. The settle time register (reset value 20) may be rewritten at
// any time the block is idle and takes effect on the next sample.
module keypad_scan_debounce (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kpsd_pkg::kpsd_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output kpsd_pkg::kpsd_out_t out_data,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata
);
    import kpsd_pkg::*;

    logic        in_vld_reg;
    kpsd_in_t    in_data_reg;
    logic        out_vld_reg;
    kpsd_out_t   out_data_reg;
    kpsd_state_t state_reg;
    kpsd_state_t state_next;
    kpsd_out_t   result;
    logic [7:0]  settle_ms_reg;
    logic        advance;

    // The captured sample moves on when the output register is empty or is
    // being emptied in this same cycle.
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    kpsd_step u_step (
        .state_cur (state_reg),
        .item      (in_data_reg),
        .settle_ms (settle_ms_reg),
        .state_new (state_next),
        .result    (result)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ms_reg <= SETTLE_MS_RESET;
        end
        else if (cfg_we)
        begin
            settle_ms_reg <= cfg_wdata;
        end
    end

    // Input stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // Input payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // Scan state advances once per processed sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.scan_first  <= '0;
            state_reg.scan_second <= '0;
            state_reg.press_mask  <= '0;
            state_reg.row_index   <= '0;
            state_reg.phase       <= PH_FIRST;
            state_reg.wait_count  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    // A reported key always carries a legend, and a result without a key carries no code.
    a_code_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((out_data_reg.key_valid == 1'b1)
                         == (out_data_reg.key_code != ASCII_NONE)))
        else $error("key_code does not agree with key_valid");

    // While waiting for the settle time, the row counter sits at the first row.
    a_wait_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_WAIT |-> state_reg.row_index == '0)
        else $error("row counter moved during the settle wait");

    // At most one key becomes masked per processed sample.
    a_one_new_press: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(state_reg.press_mask & ~$past(state_reg.press_mask)) <= 1)
        else $error("more than one key masked in one step");

    // The scan state is frozen whenever no sample is processed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("scan state changed without a processed sample");
`endif

endmodule
